// ===== hw/rtl/spwe_pkg.sv =====
// ----------------------------------------------------------------------------
// spwe_pkg
// Shared widths, codes and types for the SPI master pin word engine.
// ----------------------------------------------------------------------------
package spwe_pkg;

    localparam int PIN_W     = 32;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 6;
    localparam int CMD_W     = 2;
    localparam int MODE_W    = 4;
    localparam int CFG_IDX_W = 3;

    // Bits of the mode register.
    localparam int MODE_CPOL   = 0;
    localparam int MODE_CPHA   = 1;
    localparam int MODE_SEL_HI = 2;
    localparam int MODE_LSB    = 3;

    localparam logic KIND_PIN  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CLKIDLE,
        PH_SELECT,
        PH_TOGGLE,
        PH_FINAL,
        PH_SETCS
    } phase_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_START    = 2'd0,
        CMD_READBACK = 2'd1,
        CMD_SETCS    = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOSI_MASK   = 3'd0,
        REG_MISO_MASK   = 3'd1,
        REG_CLOCK_MASK  = 3'd2,
        REG_SELECT_MASK = 3'd3,
        REG_SPI_MODE    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [PIN_W-1:0]  mosi_mask;
        logic [PIN_W-1:0]  miso_mask;
        logic [PIN_W-1:0]  clock_mask;
        logic [PIN_W-1:0]  select_mask;
        logic [MODE_W-1:0] spi_mode;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PIN_W-1:0]  other_pins;
        logic [DATA_W-1:0] data_in;
        logic [CNT_W-1:0]  bit_count;
        logic              select_active;
        logic [PIN_W-1:0]  pins_in;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [PIN_W-1:0]  pin_word;
        logic [DATA_W-1:0] data_out;
    } result_t;

    // Reverses the low n bits of v; n never exceeds DATA_W.
    function automatic logic [DATA_W-1:0] reverse_low(input logic [DATA_W-1:0] v,
                                                      input logic [CNT_W-1:0]  n);
        logic [DATA_W-1:0] r;
        logic [CNT_W-1:0]  sh;
        for (int i = 0; i < DATA_W; i++) begin
            r[i] = v[DATA_W-1-i];
        end
        sh = CNT_W'(DATA_W) - n;
        return r >> sh;
    endfunction

endpackage

// ===== hw/rtl/spwe_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// spwe_cfg_regs
// Configuration register file: pin masks and SPI mode.
// ----------------------------------------------------------------------------
module spwe_cfg_regs
    import spwe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PIN_W-1:0]     cfg_wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_MOSI_MASK:   cfg_next.mosi_mask   = cfg_wr_data;
                REG_MISO_MASK:   cfg_next.miso_mask   = cfg_wr_data;
                REG_CLOCK_MASK:  cfg_next.clock_mask  = cfg_wr_data;
                REG_SELECT_MASK: cfg_next.select_mask = cfg_wr_data;
                REG_SPI_MODE:    cfg_next.spi_mode    = cfg_wr_data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/spwe_step.sv =====
// ----------------------------------------------------------------------------
// spwe_step
// Sequencer state and the combinational step that applies one item to it.
// ----------------------------------------------------------------------------
module spwe_step
    import spwe_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    phase_t            phase_reg, phase_next;
    logic [PIN_W-1:0]  drive_word_reg, drive_word_next;
    logic [DATA_W-1:0] tx_bits_reg, tx_bits_next;
    logic [DATA_W-1:0] bit_mask_reg, bit_mask_next;
    logic [DATA_W-1:0] rx_bits_reg, rx_bits_next;
    logic [CNT_W-1:0]  bits_left_reg, bits_left_next;
    logic [CNT_W-1:0]  bit_total_reg, bit_total_next;
    logic              second_half_reg, second_half_next;

    logic              cpol, cpha, sel_hi, lsb_first;
    logic              tx_bit, miso_bit;
    logic [CNT_W-1:0]  n_sat;
    logic [CNT_W-1:0]  bits_dec;
    logic [PIN_W-1:0]  w;

    assign cpol      = cfg.spi_mode[MODE_CPOL];
    assign cpha      = cfg.spi_mode[MODE_CPHA];
    assign sel_hi    = cfg.spi_mode[MODE_SEL_HI];
    assign lsb_first = cfg.spi_mode[MODE_LSB];
    assign tx_bit    = |(tx_bits_reg & bit_mask_reg);
    assign miso_bit  = |(item.pins_in & cfg.miso_mask);
    assign n_sat     = (item.bit_count > CNT_W'(DATA_W)) ? CNT_W'(DATA_W) : item.bit_count;
    assign bits_dec  = bits_left_reg - CNT_W'(1);

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        case (item.cmd)
            CMD_START: phase_next = PH_CLKIDLE;
            CMD_SETCS: phase_next = PH_SETCS;
            CMD_READBACK: begin
                case (phase_reg)
                    PH_CLKIDLE: phase_next = PH_SELECT;
                    PH_SELECT:  phase_next = (bits_left_reg == '0) ? PH_FINAL : PH_TOGGLE;
                    PH_TOGGLE: begin
                        if (second_half_reg && bits_dec == '0) begin
                            phase_next = PH_FINAL;
                        end
                    end
                    PH_FINAL:   phase_next = PH_IDLE;
                    PH_SETCS:   phase_next = PH_IDLE;
                    default:    phase_next = phase_reg;
                endcase
            end
            default: phase_next = phase_reg;
        endcase
    end

    // Datapath and result.
    always_comb begin
        drive_word_next  = drive_word_reg;
        tx_bits_next     = tx_bits_reg;
        bit_mask_next    = bit_mask_reg;
        rx_bits_next     = rx_bits_reg;
        bits_left_next   = bits_left_reg;
        bit_total_next   = bit_total_reg;
        second_half_next = second_half_reg;
        w                = drive_word_reg;
        res              = '0;
        res.valid        = 1'b1;
        res.kind         = KIND_PIN;
        case (item.cmd)
            CMD_START: begin
                bit_total_next   = n_sat;
                bits_left_next   = n_sat;
                tx_bits_next     = lsb_first ? reverse_low(item.data_in, n_sat) : item.data_in;
                bit_mask_next    = (n_sat != '0) ? (DATA_W'(1) << (n_sat - CNT_W'(1))) : '0;
                rx_bits_next     = '0;
                second_half_next = 1'b0;
                drive_word_next  = cpol ? (item.other_pins | cfg.clock_mask)
                                        : (item.other_pins & ~cfg.clock_mask);
            end
            CMD_SETCS: begin
                drive_word_next = (item.select_active == sel_hi)
                                ? (item.other_pins | cfg.select_mask)
                                : (item.other_pins & ~cfg.select_mask);
                rx_bits_next    = '0;
            end
            CMD_READBACK: begin
                case (phase_reg)
                    PH_CLKIDLE: begin
                        w = sel_hi ? (drive_word_reg | cfg.select_mask)
                                   : (drive_word_reg & ~cfg.select_mask);
                        if (!cpha) begin
                            w = tx_bit ? (w | cfg.mosi_mask) : (w & ~cfg.mosi_mask);
                            bit_mask_next = bit_mask_reg >> 1;
                        end
                        drive_word_next = w;
                    end
                    PH_SELECT: begin
                        if (bits_left_reg != '0) begin
                            w = drive_word_reg ^ cfg.clock_mask;
                            if (cpha) begin
                                w = tx_bit ? (w | cfg.mosi_mask) : (w & ~cfg.mosi_mask);
                                bit_mask_next = bit_mask_reg >> 1;
                            end
                            drive_word_next  = w;
                            second_half_next = 1'b0;
                        end
                    end
                    PH_TOGGLE: begin
                        if (!second_half_reg) begin
                            w = drive_word_reg ^ cfg.clock_mask;
                            if (!cpha) begin
                                rx_bits_next  = {rx_bits_reg[DATA_W-2:0], miso_bit};
                                w = tx_bit ? (w | cfg.mosi_mask) : (w & ~cfg.mosi_mask);
                                bit_mask_next = bit_mask_reg >> 1;
                            end
                            drive_word_next  = w;
                            second_half_next = 1'b1;
                        end else begin
                            if (cpha) begin
                                rx_bits_next = {rx_bits_reg[DATA_W-2:0], miso_bit};
                            end
                            bits_left_next   = bits_dec;
                            second_half_next = 1'b0;
                            if (bits_dec != '0) begin
                                w = drive_word_reg ^ cfg.clock_mask;
                                if (cpha) begin
                                    w = tx_bit ? (w | cfg.mosi_mask) : (w & ~cfg.mosi_mask);
                                    bit_mask_next = bit_mask_reg >> 1;
                                end
                                drive_word_next = w;
                            end
                        end
                    end
                    PH_FINAL: begin
                        res.kind     = KIND_DONE;
                        res.data_out = lsb_first ? reverse_low(rx_bits_reg, bit_total_reg)
                                                 : rx_bits_reg;
                    end
                    PH_SETCS: begin
                        res.kind = KIND_DONE;
                    end
                    default: begin
                        res.valid = 1'b0;
                    end
                endcase
            end
            default: begin
                res.valid = 1'b0;
            end
        endcase
        res.pin_word = drive_word_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            drive_word_reg  <= '0;
            tx_bits_reg     <= '0;
            bit_mask_reg    <= '0;
            rx_bits_reg     <= '0;
            bits_left_reg   <= '0;
            bit_total_reg   <= '0;
            second_half_reg <= 1'b0;
        end else if (fire) begin
            phase_reg       <= phase_next;
            drive_word_reg  <= drive_word_next;
            tx_bits_reg     <= tx_bits_next;
            bit_mask_reg    <= bit_mask_next;
            rx_bits_reg     <= rx_bits_next;
            bits_left_reg   <= bits_left_next;
            bit_total_reg   <= bit_total_next;
            second_half_reg <= second_half_next;
        end
    end

    // Clock toggling only ever runs with bits still to go.
    a_toggle_has_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_TOGGLE |-> bits_left_reg != '0)
        else $error("toggle phase with no bits left");

    a_bits_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_left_reg <= bit_total_reg && bit_total_reg <= CNT_W'(DATA_W))
        else $error("bit counters out of range");

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.valid && res.kind == KIND_DONE |=> phase_reg == PH_IDLE)
        else $error("finished result did not return to idle");

endmodule

// ===== hw/rtl/spi_master_pin_word_engine_top.sv =====
// ----------------------------------------------------------------------------
// spi_master_pin_word_engine_top
// SPI master that bit-bangs a 32-bit pin word through configurable pin masks.
// ----------------------------------------------------------------------------
// The engine takes one word per clock cycle unless m_ready stalls it. A word
// passes through an input register, then the step logic, then the result
// register, which holds its result, if any. A start word loads the
// transfer and returns the first pin word to drive (clock at its idle level);
// each following pin readback word returns the next pin word to drive, with
// the chip select asserted, then the clock toggles that shift each bit, and at last a
// "finished" result that carries the received bits right aligned. A set
// select word returns one pin word and its readback returns "finished". A
// readback while idle, and the unused command code, give no result. The rate
// is set by the step logic, which updates the sequencer state once per word;
// in practice the pin interface that answers each pin word sets the pace.
// Configuration registers are written through a plain write port and must
// only be changed while no operation is in progress.
// ----------------------------------------------------------------------------
module spi_master_pin_word_engine_top
    import spwe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PIN_W-1:0]     cfg_wr_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_cmd,
    input  logic [PIN_W-1:0]     s_other_pins,
    input  logic [DATA_W-1:0]    s_data_in,
    input  logic [CNT_W-1:0]     s_bit_count,
    input  logic                 s_select_active,
    input  logic [PIN_W-1:0]     s_pins_in,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_kind,
    output logic [PIN_W-1:0]     m_pin_word,
    output logic [DATA_W-1:0]    m_data_out
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg, in_valid_next;
    result_t step_res;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;
    logic    advance;

    spwe_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // A registered word moves into the step logic whenever the result
    // register is empty or is being emptied in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (advance) begin
            out_valid_next = step_res.valid;
        end
    end

    spwe_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.cmd           <= s_cmd;
            in_item_reg.other_pins    <= s_other_pins;
            in_item_reg.data_in       <= s_data_in;
            in_item_reg.bit_count     <= s_bit_count;
            in_item_reg.select_active <= s_select_active;
            in_item_reg.pins_in       <= s_pins_in;
        end
        if (advance && step_res.valid) begin
            out_reg <= step_res;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_kind     = out_reg.kind;
    assign m_pin_word = out_reg.pin_word;
    assign m_data_out = out_reg.data_out;

    // A word held behind a stalled result must not be lost or altered.
    a_hold_behind_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |=> in_valid_reg && $stable(in_item_reg))
        else $error("input word lost while result stalled");

    // A word that produces a result always shows it in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step_res.valid |=> out_valid_reg)
        else $error("result dropped");

    // Step fires only when the result register can take its output.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> !out_valid_reg || m_ready)
        else $error("result register overwritten");

endmodule
